// ----- src/http_response_header_parser_unit_assert.svh -----
// Assertion macros shared by the parser RTL.
`ifndef HTTP_RESPONSE_HEADER_PARSER_UNIT_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HRHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HRHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

// ----- src/hrhp_pkg.sv -----
// Shared types, phase codes and character tables of the HTTP response head parser.
`default_nettype none
package hrhp_pkg;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_PREFIX     = 4'd1;
    localparam logic [3:0] PH_PREFIX_BAD = 4'd2;
    localparam logic [3:0] PH_MAJOR      = 4'd3;
    localparam logic [3:0] PH_MINOR      = 4'd4;
    localparam logic [3:0] PH_CODE       = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_REASON     = 4'd7;
    localparam logic [3:0] PH_LINE_CR    = 4'd8;
    localparam logic [3:0] PH_LINE_BAD   = 4'd9;
    localparam logic [3:0] PH_NAME       = 4'd10;
    localparam logic [3:0] PH_CL_SKIP    = 4'd11;
    localparam logic [3:0] PH_CL_DIGITS  = 4'd12;
    localparam logic [3:0] PH_VALUE      = 4'd13;
    localparam logic [3:0] PH_END_CR     = 4'd14;

    localparam logic [1:0] OUT_DONE   = 2'd0;
    localparam logic [1:0] OUT_PROTO  = 2'd1;
    localparam logic [1:0] OUT_HEADER = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [4:0] PREFIX_LEN = 5'd5;
    localparam logic [4:0] CODE_LEN   = 5'd3;
    localparam logic [4:0] CL_LEN     = 5'd15;
    localparam logic [4:0] TE_LEN     = 5'd18;
    localparam logic [4:0] POS_MAX    = 5'd31;

    localparam logic [9:0] STATUS_MAX = 10'd999;

    // Match bits of the header name: bit 0 Content-Length, bit 1 Transfer-Encoding.
    localparam logic [1:0] MATCH_BOTH = 2'b11;

    // Fixed-width part of the parser state.
    typedef struct packed {
        logic [3:0]  phase;
        logic [4:0]  position;
        logic [15:0] major_acc;
        logic [15:0] minor_acc;
        logic [9:0]  code_acc;
        logic        te_flag;
        logic [1:0]  name_match;
        logic        name_started;
    } state_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            5'd17:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // Saturating decimal step for the 16-bit version accumulators.
    function automatic logic [15:0] sat_dec16(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] w;
        w = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, d};
        return (w[19:16] != 4'd0) ? 16'hFFFF : w[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/hrhp_step.sv -----
// Next-state and result logic for one byte of the response head.
`default_nettype none
module hrhp_step #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  var hrhp_pkg::state_t   cur,
    input  wire [LENGTH_BITS-1:0]  cur_length,
    input  wire [COUNT_BITS-1:0]   cur_count,
    input  wire [7:0]              data_byte,
    input  wire                    start_req,
    output hrhp_pkg::state_t       nxt,
    output logic [LENGTH_BITS-1:0] nxt_length,
    output logic [COUNT_BITS-1:0]  nxt_count,
    output logic                   res_valid,
    output logic [1:0]             res_outcome
);

    localparam int LW = LENGTH_BITS + 4;

    hrhp_pkg::state_t       s;
    logic [LENGTH_BITS-1:0] len_s;
    logic [COUNT_BITS-1:0]  cnt_s;
    logic                   is_digit;
    logic [3:0]             d;
    logic [7:0]             lb;
    logic                   bad;
    logic [4:0]             pos_inc;
    logic [LW-1:0]          len_wide;
    logic [LENGTH_BITS-1:0] len_sat;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [9:0]             code_step;

    assign is_digit = (data_byte >= hrhp_pkg::CH_ZERO) && (data_byte <= hrhp_pkg::CH_NINE);
    assign d        = 4'(data_byte - hrhp_pkg::CH_ZERO);
    assign lb       = hrhp_pkg::to_lower(data_byte);

    always_comb
    begin
        // A start byte clears everything and is then parsed as the first prefix byte.
        if (start_req)
        begin
            s            = '0;
            s.phase      = hrhp_pkg::PH_PREFIX;
            s.name_match = hrhp_pkg::MATCH_BOTH;
            len_s        = '0;
            cnt_s        = '0;
        end
        else
        begin
            s     = cur;
            len_s = cur_length;
            cnt_s = cur_count;
        end
    end

    assign pos_inc   = s.position + 5'd1;
    assign len_wide  = ({4'd0, len_s} << 3) + ({4'd0, len_s} << 1) + LW'(d);
    assign len_sat   = (len_wide[LW-1:LENGTH_BITS] != 4'd0) ? '1 : len_wide[LENGTH_BITS-1:0];
    assign cnt_inc   = (cnt_s == '1) ? cnt_s : cnt_s + 1'b1;
    assign code_step = (s.code_acc << 3) + (s.code_acc << 1) + 10'(d);

    always_comb
    begin
        nxt         = s;
        nxt_length  = len_s;
        nxt_count   = cnt_s;
        res_valid   = 1'b0;
        res_outcome = hrhp_pkg::OUT_DONE;
        bad         = 1'b0;
        case (s.phase)
            hrhp_pkg::PH_PREFIX, hrhp_pkg::PH_PREFIX_BAD:
            begin
                bad = (s.position > 5'd4) || (data_byte != hrhp_pkg::prefix_char(s.position[2:0]))
                      || (s.phase == hrhp_pkg::PH_PREFIX_BAD);
                nxt.position = pos_inc;
                nxt.phase    = bad ? hrhp_pkg::PH_PREFIX_BAD : s.phase;
                if (pos_inc >= hrhp_pkg::PREFIX_LEN)
                begin
                    if (bad)
                    begin
                        res_valid   = 1'b1;
                        res_outcome = hrhp_pkg::OUT_PROTO;
                    end
                    else
                    begin
                        nxt.phase = hrhp_pkg::PH_MAJOR;
                    end
                end
            end
            hrhp_pkg::PH_MAJOR:
            begin
                if (is_digit)
                begin
                    nxt.major_acc = hrhp_pkg::sat_dec16(s.major_acc, d);
                end
                else if (data_byte == hrhp_pkg::CH_DOT)
                begin
                    nxt.phase = hrhp_pkg::PH_MINOR;
                end
                else
                begin
                    res_valid   = 1'b1;
                    res_outcome = hrhp_pkg::OUT_PROTO;
                end
            end
            hrhp_pkg::PH_MINOR:
            begin
                if (is_digit)
                begin
                    nxt.minor_acc = hrhp_pkg::sat_dec16(s.minor_acc, d);
                end
                else if (data_byte == hrhp_pkg::CH_SPACE)
                begin
                    nxt.phase    = hrhp_pkg::PH_CODE;
                    nxt.position = '0;
                end
                else
                begin
                    res_valid   = 1'b1;
                    res_outcome = hrhp_pkg::OUT_PROTO;
                end
            end
            hrhp_pkg::PH_CODE:
            begin
                if (is_digit)
                begin
                    nxt.code_acc = code_step;
                end
                nxt.position = pos_inc;
                if (pos_inc >= hrhp_pkg::CODE_LEN)
                begin
                    nxt.phase = hrhp_pkg::PH_SKIP;
                end
            end
            hrhp_pkg::PH_SKIP:
            begin
                nxt.phase = hrhp_pkg::PH_REASON;
            end
            hrhp_pkg::PH_REASON, hrhp_pkg::PH_VALUE:
            begin
                if (data_byte == hrhp_pkg::CH_CR || data_byte == hrhp_pkg::CH_LF)
                begin
                    if (s.phase == hrhp_pkg::PH_VALUE)
                    begin
                        nxt_count = cnt_inc;
                    end
                    nxt.phase = (data_byte == hrhp_pkg::CH_CR) ? hrhp_pkg::PH_LINE_CR
                                                               : hrhp_pkg::PH_LINE_BAD;
                end
            end
            hrhp_pkg::PH_LINE_CR:
            begin
                if (data_byte != hrhp_pkg::CH_LF)
                begin
                    res_valid   = 1'b1;
                    res_outcome = hrhp_pkg::OUT_HEADER;
                end
                else
                begin
                    nxt.phase        = hrhp_pkg::PH_NAME;
                    nxt.position     = '0;
                    nxt.name_match   = hrhp_pkg::MATCH_BOTH;
                    nxt.name_started = 1'b0;
                end
            end
            hrhp_pkg::PH_LINE_BAD:
            begin
                res_valid   = 1'b1;
                res_outcome = hrhp_pkg::OUT_HEADER;
            end
            hrhp_pkg::PH_NAME:
            begin
                if (data_byte == hrhp_pkg::CH_CR)
                begin
                    nxt.phase = hrhp_pkg::PH_END_CR;
                end
                else if (data_byte == hrhp_pkg::CH_LF)
                begin
                    res_valid   = 1'b1;
                    res_outcome = hrhp_pkg::OUT_HEADER;
                end
                else
                begin
                    nxt.name_started = 1'b1;
                    if (s.position >= hrhp_pkg::CL_LEN || lb != hrhp_pkg::cl_char(s.position[3:0]))
                    begin
                        nxt.name_match[0] = 1'b0;
                    end
                    if (s.position >= hrhp_pkg::TE_LEN || lb != hrhp_pkg::te_char(s.position))
                    begin
                        nxt.name_match[1] = 1'b0;
                    end
                    if (s.position < hrhp_pkg::POS_MAX)
                    begin
                        nxt.position = pos_inc;
                    end
                    if (data_byte == hrhp_pkg::CH_COLON)
                    begin
                        if (nxt.name_match[0] && nxt.position == hrhp_pkg::CL_LEN)
                        begin
                            nxt.phase = hrhp_pkg::PH_CL_SKIP;
                        end
                        else
                        begin
                            if (nxt.name_match[1] && nxt.position == hrhp_pkg::TE_LEN)
                            begin
                                nxt.te_flag = 1'b1;
                            end
                            nxt.phase = hrhp_pkg::PH_VALUE;
                        end
                    end
                end
            end
            hrhp_pkg::PH_CL_SKIP:
            begin
                nxt.phase = hrhp_pkg::PH_CL_DIGITS;
            end
            hrhp_pkg::PH_CL_DIGITS:
            begin
                if (is_digit)
                begin
                    nxt_length = len_sat;
                end
                else
                begin
                    nxt_count = cnt_inc;
                    nxt.phase = (data_byte == hrhp_pkg::CH_CR) ? hrhp_pkg::PH_LINE_CR
                                                               : hrhp_pkg::PH_LINE_BAD;
                end
            end
            hrhp_pkg::PH_END_CR:
            begin
                res_valid   = 1'b1;
                res_outcome = (data_byte != hrhp_pkg::CH_LF) ? hrhp_pkg::OUT_HEADER
                                                             : hrhp_pkg::OUT_DONE;
            end
            default:
            begin
                // Waiting for a new response: the byte is dropped.
            end
        endcase
        if (res_valid)
        begin
            nxt.phase = hrhp_pkg::PH_IDLE;
        end
    end

endmodule
`default_nettype wire

// ----- src/http_response_header_parser_unit.sv -----
// Top level of the byte-serial HTTP response head parser.
//
// The parser takes one byte of an HTTP response head per item on the slave
// stream and gives at most one result item per response on the master stream:
// either the parsed head (version, status code, Content-Length total,
// Transfer-Encoding flag and header count) once the blank line arrives, or a
// protocol or header error with the fields gathered so far. A byte with
// start_req set on tuser begins a new response and clears all fields; bytes
// that arrive while no response is open are dropped. The block takes one byte
// every cycle. Each byte lands in an input register, from which the next-state
// logic (one compare against the match tables and one multiply by ten done as
// shift-and-add) updates the parser state and, where the byte ends the head or
// breaks a rule, loads the result register. The last byte thus passes through
// the input register and then the result register before m_tvalid rises.
// While a result waits in the result register and the master side is not ready,
// the byte in the input register is held and s_tready stays low, so no byte
// moves until the result is taken; otherwise a byte is taken in every cycle.
// Accumulators saturate at their maximum rather than wrap.
`default_nettype none
module http_response_header_parser_unit #(
    parameter int LENGTH_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  wire         m_tready,
    // [15:0] major_version, [31:16] minor_version, [41:32] status_code,
    // [73:42] content_length, [74] transfer_encoding_seen, [90:75] header_count,
    // [95:91] zero
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] outcome
);

`include "http_response_header_parser_unit_assert.svh"

    // Input register.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;

    // Parser state.
    hrhp_pkg::state_t       st_reg;
    hrhp_pkg::state_t       st_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [COUNT_BITS-1:0]  cnt_next;

    // Result register.
    logic                   out_valid_reg;
    logic [95:0]            out_data_reg;
    logic [1:0]             out_kind_reg;

    logic                   res_valid;
    logic [1:0]             res_outcome;
    logic                   advance;
    logic                   process;
    logic [95:0]            res_data;

    // The state advances whenever the result register is free or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    hrhp_step #(
        .LENGTH_BITS(LENGTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cur        (st_reg),
        .cur_length (len_reg),
        .cur_count  (cnt_reg),
        .data_byte  (in_byte_reg),
        .start_req  (in_start_reg),
        .nxt        (st_next),
        .nxt_length (len_next),
        .nxt_count  (cnt_next),
        .res_valid  (res_valid),
        .res_outcome(res_outcome)
    );

    // Result fields are the accumulators as they stand after this byte.
    assign res_data = {5'd0,
                       16'(cnt_next),
                       st_next.te_flag,
                       32'(len_next),
                       st_next.code_acc,
                       st_next.minor_acc,
                       st_next.major_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            // Fields in order: phase, position, major, minor, code, te flag,
            // name match, name started.
            st_reg        <= {hrhp_pkg::PH_IDLE, 5'd0, 16'd0, 16'd0, 10'd0, 1'b0,
                              hrhp_pkg::MATCH_BOTH, 1'b0};
            len_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (process)
            begin
                st_reg  <= st_next;
                len_reg <= len_next;
                cnt_reg <= cnt_next;
            end
            if (advance)
            begin
                out_valid_reg <= process && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (process && res_valid)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_outcome;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // A byte waiting in the input register is not lost while the output stalls.
    `HRHP_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg)
    // Only the three defined outcome codes reach the port.
    `HRHP_ASSERT_NOW(a_outcome_code, out_valid_reg,
        out_kind_reg == hrhp_pkg::OUT_DONE || out_kind_reg == hrhp_pkg::OUT_PROTO ||
        out_kind_reg == hrhp_pkg::OUT_HEADER)
    // After producing a result the parser waits for the next response.
    `HRHP_ASSERT_NEXT(a_idle_after_result, process && res_valid,
        st_reg.phase == hrhp_pkg::PH_IDLE && out_valid_reg)
    // The status code never exceeds three decimal digits.
    `HRHP_ASSERT_NOW(a_status_range, out_valid_reg, out_data_reg[41:32] <= hrhp_pkg::STATUS_MAX)

endmodule
`default_nettype wire
